// ===== src/i2stx_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2stx_pkg
// Shared types, register map and sizes of the I2S transmit buffer.
// ----------------------------------------------------------------------------
package i2stx_pkg;

    localparam int RING_DEPTH = 16384;
    localparam int PTR_W      = $clog2(RING_DEPTH);
    localparam int CNT_W      = $clog2(RING_DEPTH + 1);

    localparam int CREDIT_W   = 12;
    localparam int SAMPLE_W   = 16;
    localparam int WORD_W     = 32;
    localparam int OFS_W      = 8;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CREDIT_W-1:0] CREDITS_PER_TICK_RST = CREDIT_W'(882);
    localparam logic [CREDIT_W-1:0] CREDIT_LIMIT_RST     = CREDIT_W'(3528);

    localparam logic [OFS_W-1:0] OFS_CLOCK_CONTROL    = 8'h00;
    localparam logic [OFS_W-1:0] OFS_TRANSMIT_CONTROL = 8'h04;
    localparam logic [OFS_W-1:0] OFS_TRANSMIT_COMMAND = 8'h08;
    localparam logic [OFS_W-1:0] OFS_DATA             = 8'h10;
    localparam logic [OFS_W-1:0] OFS_STATUS           = 8'h3c;
    localparam logic [OFS_W-1:0] OFS_CLOCK_DIVIDER    = 8'h40;

    localparam int RUN_BIT = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_MODE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CREDITS_PER_TICK = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CREDIT_LIMIT     = 2'd2;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_DRAIN = 2'd2,
        OP_TICK  = 2'd3
    } op_t;

    typedef struct packed {
        logic                wr_en;
        logic [PTR_W-1:0]    wr_addr;
        logic [SAMPLE_W-1:0] wr_data;
        logic                rd_en;
        logic [PTR_W-1:0]    rd_addr;
    } ring_req_t;

    typedef struct packed {
        logic [WORD_W-1:0] read_data;
        logic              dma_request;
        logic              sample_valid;
        logic              tx_running;
        logic [CNT_W-1:0]  fill_level;
    } result_t;

endpackage
`default_nettype wire

// ===== src/i2stx_ring_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2stx_ring_ram
// Single-port-write, single-port-read sample memory with registered read data.
// ----------------------------------------------------------------------------
module i2stx_ring_ram (
    input  wire logic                          aclk,
    input  wire i2stx_pkg::ring_req_t          req,
    output logic [i2stx_pkg::SAMPLE_W-1:0]     rd_data
);
    import i2stx_pkg::*;

    logic [SAMPLE_W-1:0] mem [RING_DEPTH];

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            rd_data <= mem[req.rd_addr];
        end
    end

endmodule
`default_nettype wire

// ===== src/i2stx_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2stx_ctrl
// Register file, ring pointers and credit counter; one request per cycle while go is high.
// ----------------------------------------------------------------------------
module i2stx_ctrl (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               go,
    input  wire i2stx_pkg::op_t                     op,
    input  wire logic [i2stx_pkg::OFS_W-1:0]        offset,
    input  wire logic [i2stx_pkg::WORD_W-1:0]       write_data,
    input  wire logic                               cfg_wr_en,
    input  wire logic [i2stx_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [i2stx_pkg::CREDIT_W-1:0]     cfg_wdata,
    output i2stx_pkg::ring_req_t                    ring_req,
    output i2stx_pkg::result_t                      result
);
    import i2stx_pkg::*;

    logic                buffer_mode_reg;
    logic [CREDIT_W-1:0] credits_per_tick_reg;
    logic [CREDIT_W-1:0] credit_limit_reg;

    logic [WORD_W-1:0]   clock_control_reg,    clock_control_next;
    logic [WORD_W-1:0]   transmit_control_reg, transmit_control_next;
    logic [WORD_W-1:0]   transmit_command_reg, transmit_command_next;
    logic [WORD_W-1:0]   clock_divider_reg,    clock_divider_next;
    logic [PTR_W-1:0]    ring_oldest_reg,      ring_oldest_next;
    logic [CNT_W-1:0]    ring_count_reg,       ring_count_next;
    logic [CREDIT_W-1:0] credit_count_reg,     credit_count_next;

    logic                running;
    logic                running_next;
    logic                ring_full;
    logic [CNT_W:0]      slot_sum;
    logic [PTR_W-1:0]    slot;
    logic [CREDIT_W:0]   credit_sum;
    logic                room;

    // config port
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buffer_mode_reg      <= 1'b0;
            credits_per_tick_reg <= CREDITS_PER_TICK_RST;
            credit_limit_reg     <= CREDIT_LIMIT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_BUFFER_MODE:      buffer_mode_reg      <= cfg_wdata[0];
                CFG_CREDITS_PER_TICK: credits_per_tick_reg <= cfg_wdata;
                CFG_CREDIT_LIMIT:     credit_limit_reg     <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign running    = transmit_command_reg[RUN_BIT];
    assign ring_full  = (ring_count_reg >= CNT_W'(RING_DEPTH));
    assign slot_sum   = {1'b0, CNT_W'(ring_oldest_reg)} + {1'b0, ring_count_reg};
    assign slot       = (slot_sum >= (CNT_W + 1)'(RING_DEPTH))
                        ? PTR_W'(slot_sum - (CNT_W + 1)'(RING_DEPTH))
                        : PTR_W'(slot_sum);
    assign credit_sum = {1'b0, credit_count_reg} + {1'b0, credits_per_tick_reg};

    always_comb begin
        clock_control_next    = clock_control_reg;
        transmit_control_next = transmit_control_reg;
        transmit_command_next = transmit_command_reg;
        clock_divider_next    = clock_divider_reg;
        ring_oldest_next      = ring_oldest_reg;
        ring_count_next       = ring_count_reg;
        credit_count_next     = credit_count_reg;

        ring_req.wr_en   = 1'b0;
        ring_req.wr_addr = slot;
        ring_req.wr_data = write_data[SAMPLE_W-1:0];
        ring_req.rd_en   = 1'b0;
        ring_req.rd_addr = ring_oldest_reg;

        result.read_data    = '0;
        result.sample_valid = 1'b0;

        case (op)
            OP_READ: begin
                case (offset)
                    OFS_CLOCK_CONTROL:    result.read_data = clock_control_reg;
                    OFS_TRANSMIT_CONTROL: result.read_data = transmit_control_reg;
                    OFS_TRANSMIT_COMMAND: result.read_data = transmit_command_reg;
                    OFS_STATUS:           result.read_data = '0;
                    OFS_CLOCK_DIVIDER:    result.read_data = clock_divider_reg;
                    default:              result.read_data = '0;
                endcase
            end
            OP_WRITE: begin
                case (offset)
                    OFS_CLOCK_CONTROL:    clock_control_next    = write_data;
                    OFS_TRANSMIT_CONTROL: transmit_control_next = write_data;
                    OFS_TRANSMIT_COMMAND: transmit_command_next = write_data;
                    OFS_CLOCK_DIVIDER:    clock_divider_next    = write_data;
                    OFS_DATA: begin
                        if (buffer_mode_reg) begin
                            if (!ring_full) begin
                                ring_req.wr_en  = go;
                                ring_count_next = ring_count_reg + CNT_W'(1);
                            end
                        end else if (credit_count_reg != '0) begin
                            credit_count_next = credit_count_reg - CREDIT_W'(1);
                        end
                    end
                    default: ;
                endcase
            end
            OP_DRAIN: begin
                if (running && buffer_mode_reg && ring_count_reg != '0) begin
                    ring_req.rd_en      = go;
                    result.sample_valid = 1'b1;
                    ring_count_next     = ring_count_reg - CNT_W'(1);
                    ring_oldest_next    = (ring_oldest_reg == PTR_W'(RING_DEPTH - 1))
                                          ? '0 : ring_oldest_reg + PTR_W'(1);
                end
            end
            OP_TICK: begin
                if (running) begin
                    credit_count_next = (credit_sum < {1'b0, credit_limit_reg})
                                        ? credit_sum[CREDIT_W-1:0] : credit_limit_reg;
                end
            end
            default: ;
        endcase

        running_next = transmit_command_next[RUN_BIT];
        room = buffer_mode_reg ? (ring_count_next < CNT_W'(RING_DEPTH))
                               : (credit_count_next != '0);
        result.dma_request = running_next && room;
        result.tx_running  = running_next;
        result.fill_level  = ring_count_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clock_control_reg    <= '0;
            transmit_control_reg <= '0;
            transmit_command_reg <= '0;
            clock_divider_reg    <= '0;
            ring_oldest_reg      <= '0;
            ring_count_reg       <= '0;
            credit_count_reg     <= '0;
        end else if (go) begin
            clock_control_reg    <= clock_control_next;
            transmit_control_reg <= transmit_control_next;
            transmit_command_reg <= transmit_command_next;
            clock_divider_reg    <= clock_divider_next;
            ring_oldest_reg      <= ring_oldest_next;
            ring_count_reg       <= ring_count_next;
            credit_count_reg     <= credit_count_next;
        end
    end

endmodule
`default_nettype wire

// ===== src/i2s_tx_dma_paced_buffer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Pipeline: an accepted request is held in the input register, then passes through the control
// logic and sample memory read in one pass into the result register, from where it is taken.
// Throughput: one request per cycle while m_tready is high; a stalled result holds the
// input register. Reset: synchronous, active low; clears registers, ring pointers,
// credits and config to their defaults. The sample memory needs no clearing pass.
// ----------------------------------------------------------------------------
// i2s_tx_dma_paced_buffer
// I2S transmit register block with ring buffer or credit pacing of DMA.
// ----------------------------------------------------------------------------
module i2s_tx_dma_paced_buffer (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // [7:0] offset, [39:8] write_data
    input  wire logic [39:0]                        s_tdata,
    // [1:0] operation
    input  wire logic [1:0]                         s_tuser,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // [31:0] read_data, [32] dma_request, [48:33] sample_out,
    // [49] tx_running, [64:50] fill_level, [71:65] zero
    output logic [71:0]                             m_tdata,
    // [0] sample_valid
    output logic                                    m_tuser,
    input  wire logic                               cfg_wr_en,
    input  wire logic [i2stx_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [i2stx_pkg::CREDIT_W-1:0]     cfg_wdata
);
    import i2stx_pkg::*;

    logic                in_valid_reg;
    op_t                 in_op_reg;
    logic [OFS_W-1:0]    in_offset_reg;
    logic [WORD_W-1:0]   in_wdata_reg;

    logic                out_valid_reg;
    result_t             out_reg;

    logic                advance;
    ring_req_t           ring_req;
    result_t             result;
    logic [SAMPLE_W-1:0] ring_q;
    logic [SAMPLE_W-1:0] sample_out;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_op_reg     <= op_t'(s_tuser);
            in_offset_reg <= s_tdata[7:0];
            in_wdata_reg  <= s_tdata[39:8];
        end
    end

    i2stx_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .go         (advance),
        .op         (in_op_reg),
        .offset     (in_offset_reg),
        .write_data (in_wdata_reg),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .ring_req   (ring_req),
        .result     (result)
    );

    i2stx_ring_ram u_ring (
        .aclk    (aclk),
        .req     (ring_req),
        .rd_data (ring_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_tready) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= result;
        end
    end

    assign sample_out = out_reg.sample_valid ? ring_q : '0;

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.sample_valid;
    assign m_tdata  = {7'd0, 15'(out_reg.fill_level), out_reg.tx_running, sample_out,
                       out_reg.dma_request, out_reg.read_data};

endmodule
`default_nettype wire

// ===== src/i2stx_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2stx_checker
// Port-level checks of the I2S transmit buffer, bound to the top level.
// ----------------------------------------------------------------------------
module i2stx_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [71:0] m_tdata,
    input  wire logic        m_tuser
);
    import i2stx_pkg::*;

    a_dma_needs_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[32] |-> m_tdata[49])
        else $error("dma request while not running");

    a_sample_needs_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[49])
        else $error("sample delivered while not running");

    a_no_sample_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[48:33] == 16'd0)
        else $error("sample data without sample valid");

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[64:50] <= 15'(RING_DEPTH))
        else $error("fill level beyond ring depth");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

endmodule

bind i2s_tx_dma_paced_buffer i2stx_checker u_i2stx_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire
